@@ rtl/ata_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the accelerometer tilt-angle block
// no dependencies; used by every module of the block

package ata_pkg;

	localparam int AXIS_W    = 16;  // raw axis width
	localparam int ANG_W     = 17;  // output angle width, degrees * 256
	localparam int VEC_W     = 28;  // cordic vector width, counts * 256 plus growth
	localparam int ACC_W     = 27;  // angle accumulator width, degrees * 65536
	localparam int TABLE_LEN = 24;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	// register index, taken from paddr[2]
	localparam logic REG_SENSOR_PRESENT = 1'b0;

	localparam logic signed [ACC_W-1:0] DEG180_Q16 = ACC_W'(180 * 65536);
	localparam logic signed [ANG_W-1:0] OUT_LIMIT  = ANG_W'(46080);

	// atan(2^-i) in degrees * 65536
	localparam logic signed [ACC_W-1:0] ATAN_Q16 [TABLE_LEN] = '{
		ACC_W'(2949120), ACC_W'(1740967), ACC_W'(919879), ACC_W'(466945),
		ACC_W'(234379),  ACC_W'(117304),  ACC_W'(58666),  ACC_W'(29335),
		ACC_W'(14668),   ACC_W'(7334),    ACC_W'(3667),   ACC_W'(1833),
		ACC_W'(917),     ACC_W'(458),     ACC_W'(229),    ACC_W'(115),
		ACC_W'(57),      ACC_W'(29),      ACC_W'(14),     ACC_W'(7),
		ACC_W'(4),       ACC_W'(2),       ACC_W'(1),      ACC_W'(0)
	};

	// what one lane hands to the merging stage
	typedef struct packed {
		logic signed [ACC_W-1:0] acc;
		logic                    num_zero;
		logic                    den_neg;
	} lane_res_t;

endpackage

@@ rtl/ata_lane.sv @@
`timescale 1ns / 1ps
// one atan2 lane: quadrant correction stage and an unrolled vectoring cordic
// depends on ata_pkg; stage loads come from the pipeline control in the top level

module ata_lane #(
	parameter int ITER = 16
) (
	input  logic                                clk,
	input  logic signed [ata_pkg::AXIS_W-1:0]   num,
	input  logic signed [ata_pkg::AXIS_W-1:0]   den,
	input  logic [ITER:0]                       ld,
	output ata_pkg::lane_res_t                  res
);
	import ata_pkg::*;

	logic signed [VEC_W-1:0] num_w, den_w, x_in, y_in;
	logic signed [ACC_W-1:0] acc_in;

	logic signed [VEC_W-1:0] x_sn   [ITER+1];
	logic signed [VEC_W-1:0] y_sn   [ITER+1];
	logic signed [ACC_W-1:0] acc_sn [ITER+1];
	logic                    zero_sn [ITER+1];
	logic                    dneg_sn [ITER+1];

	always_comb begin
		num_w  = {{(VEC_W-AXIS_W-8){num[AXIS_W-1]}}, num, 8'b0};
		den_w  = {{(VEC_W-AXIS_W-8){den[AXIS_W-1]}}, den, 8'b0};
		x_in   = den_w;
		y_in   = num_w;
		acc_in = '0;
		// left half-plane: rotate by 180 degrees first
		if (den[AXIS_W-1]) begin
			x_in   = -den_w;
			y_in   = -num_w;
			acc_in = num[AXIS_W-1] ? -DEG180_Q16 : DEG180_Q16;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			x_sn[0]    <= x_in;
			y_sn[0]    <= y_in;
			acc_sn[0]  <= acc_in;
			zero_sn[0] <= (num == '0);
			dneg_sn[0] <= den[AXIS_W-1];
		end
	end

	for (genvar j = 0; j < ITER; j++) begin : g_iter
		always_ff @(posedge clk) begin
			if (ld[j+1]) begin
				if (!y_sn[j][VEC_W-1]) begin
					x_sn[j+1]   <= x_sn[j] + (y_sn[j] >>> j);
					y_sn[j+1]   <= y_sn[j] - (x_sn[j] >>> j);
					acc_sn[j+1] <= acc_sn[j] + ATAN_Q16[j];
				end else begin
					x_sn[j+1]   <= x_sn[j] - (y_sn[j] >>> j);
					y_sn[j+1]   <= y_sn[j] + (x_sn[j] >>> j);
					acc_sn[j+1] <= acc_sn[j] - ATAN_Q16[j];
				end
				zero_sn[j+1] <= zero_sn[j];
				dneg_sn[j+1] <= dneg_sn[j];
			end
		end
	end

	assign res.acc      = acc_sn[ITER];
	assign res.num_zero = zero_sn[ITER];
	assign res.den_neg  = dneg_sn[ITER];

endmodule

@@ rtl/ata_merge.sv @@
`timescale 1ns / 1ps
// merging stage: rounds and clamps both lane angles and forms the output register
// depends on ata_pkg and on the lane result struct

module ata_merge (
	input  logic                              clk,
	input  logic                              ld,
	input  logic                              nodev,
	input  ata_pkg::lane_res_t                roll_res,
	input  ata_pkg::lane_res_t                pitch_res,
	output logic signed [ata_pkg::ANG_W-1:0]  roll_angle,
	output logic signed [ata_pkg::ANG_W-1:0]  pitch_angle,
	output logic                              status
);
	import ata_pkg::*;

	logic signed [ANG_W-1:0] roll_q, pitch_q;
	logic                    status_q;

	function automatic logic signed [ANG_W-1:0] finish(lane_res_t r);
		logic signed [ACC_W-1:0]   rnd;
		logic signed [ACC_W-9:0]   sh;
		logic signed [ANG_W-1:0]   o;
		rnd = r.acc + ACC_W'(128);
		sh  = rnd[ACC_W-1:8];
		if (sh > (ACC_W-8)'(OUT_LIMIT)) begin
			o = OUT_LIMIT;
		end else if (sh < -(ACC_W-8)'(OUT_LIMIT)) begin
			o = -OUT_LIMIT;
		end else begin
			o = sh[ANG_W-1:0];
		end
		// zero numerator: exact 0 or +180 depending on the denominator sign
		if (r.num_zero) begin
			o = r.den_neg ? OUT_LIMIT : '0;
		end
		return o;
	endfunction

	always_ff @(posedge clk) begin
		if (ld) begin
			roll_q   <= nodev ? '0 : finish(roll_res);
			pitch_q  <= nodev ? '0 : finish(pitch_res);
			status_q <= nodev;
		end
	end

	assign roll_angle  = roll_q;
	assign pitch_angle = pitch_q;
	assign status      = status_q;

endmodule

@@ rtl/accel_tilt_angles.sv @@
`timescale 1ns / 1ps
// top level of the accelerometer tilt-angle block: handshake control, register port
// depends on ata_pkg, ata_lane and ata_merge

// Roll = atan2(accel_x, accel_z) and pitch = atan2(accel_y, accel_z) in degrees * 256,
// computed by two vectoring cordic lanes side by side, one item per clock cycle while in_stall
// is low. The edge that accepts an item loads it into the quadrant correction stage; a
// register for each cordic step follows, then rounding and clamping into the output register,
// which presents the result. Every stage holds its own valid bit, so a stall at the output
// only backs up the pipeline once it is full of items. With sensor_present clear the result
// has status 1 and zero angles.
module accel_tilt_angles #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [ata_pkg::AXIS_W-1:0] accel_x,
	input  logic signed [ata_pkg::AXIS_W-1:0] accel_y,
	input  logic signed [ata_pkg::AXIS_W-1:0] accel_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [ata_pkg::ANG_W-1:0]  roll_angle,
	output logic signed [ata_pkg::ANG_W-1:0]  pitch_angle,
	output logic                              status,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ata_pkg::ADDR_W-1:0]        paddr,
	input  logic [ata_pkg::DATA_W-1:0]        pwdata,
	output logic [ata_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);
	import ata_pkg::*;

	localparam int N     = CORDIC_ITERATIONS;
	localparam int DEPTH = N + 2;

	logic             sensor_present_q;
	logic [DEPTH-1:0] vld_q;
	logic [DEPTH:0]   rdy;
	logic             nodev_sn [N+1];
	lane_res_t        roll_res, pitch_res;

	// register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_present_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == REG_SENSOR_PRESENT) begin
			sensor_present_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_SENSOR_PRESENT) begin
			prdata[0] = sensor_present_q;
		end
	end

	// a stage loads when it is empty or its content moves on
	assign rdy[DEPTH] = !out_stall;
	for (genvar k = 0; k < DEPTH; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < DEPTH; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			nodev_sn[0] <= !sensor_present_q;
		end
		for (int k = 1; k <= N; k++) begin
			if (rdy[k]) begin
				nodev_sn[k] <= nodev_sn[k-1];
			end
		end
	end

	ata_lane #(.ITER(N)) u_roll (
		.clk (clk),
		.num (accel_x),
		.den (accel_z),
		.ld  (rdy[N:0]),
		.res (roll_res)
	);

	ata_lane #(.ITER(N)) u_pitch (
		.clk (clk),
		.num (accel_y),
		.den (accel_z),
		.ld  (rdy[N:0]),
		.res (pitch_res)
	);

	ata_merge u_merge (
		.clk         (clk),
		.ld          (rdy[N+1]),
		.nodev       (nodev_sn[N]),
		.roll_res    (roll_res),
		.pitch_res   (pitch_res),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle),
		.status      (status)
	);

endmodule

@@ rtl/ata_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the accelerometer tilt-angle block
// sees only the top-level ports; attached by the bind at the end of this file

module ata_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [ata_pkg::ANG_W-1:0]   roll_angle,
	input logic signed [ata_pkg::ANG_W-1:0]   pitch_angle,
	input logic                               status,
	input logic                               psel,
	input logic                               penable,
	input logic                               pwrite,
	input logic [ata_pkg::ADDR_W-1:0]         paddr,
	input logic [ata_pkg::DATA_W-1:0]         pwdata,
	input logic [ata_pkg::DATA_W-1:0]         prdata
);

	// no sensor means zero angles
	a_nodev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> roll_angle == '0 && pitch_angle == '0)
		else $error("no-device item carries non-zero angles");

	// angles stay within plus and minus 180 degrees
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> roll_angle >= -46080 && roll_angle <= 46080
			&& pitch_angle >= -46080 && pitch_angle <= 46080)
		else $error("angle outside range");

	// a stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(roll_angle)
			&& $stable(pitch_angle) && $stable(status))
		else $error("stalled item changed");

	// the sensor-present register reads back what was written
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[2] == ata_pkg::REG_SENSOR_PRESENT
		|=> paddr[2] != ata_pkg::REG_SENSOR_PRESENT || prdata[0] == $past(pwdata[0]))
		else $error("sensor-present register read-back mismatch");

endmodule

bind accel_tilt_angles ata_checker u_ata_checker (.*);

@@ verif/accel_tilt_angles_test.sv @@
`timescale 1ns / 1ps
// self-checking bench for accel_tilt_angles: drives samples and register writes, predicts
// roll and pitch with its own cordic model and checks every result in order
// depends on ata_pkg and the accel_tilt_angles rtl

localparam logic STATUS_OK        = 1'b0;
localparam logic STATUS_NO_SENSOR = 1'b1;

typedef struct packed {
	logic signed [ata_pkg::ANG_W-1:0] roll;
	logic signed [ata_pkg::ANG_W-1:0] pitch;
	logic                             status;
} tilt_result_t;

class angle_scoreboard;
	localparam longint ANGLE_LIMIT   = 46080;
	localparam longint HALF_TURN_Q16 = 180 * 65536;
	localparam int     ATAN_ENTRIES  = 24;

	int           cordic_steps;
	bit           sensor_on;
	tilt_result_t pending_angles[$];
	int           errors;
	int           samples;
	int           checked;

	function new(int steps_i);
		cordic_steps = steps_i;
		sensor_on = 1'b0;
		errors = 0;
		samples = 0;
		checked = 0;
	endfunction

	// only index zero holds a register, the other index is ignored
	function void write_reg(logic index, logic [31:0] value);
		if (index == ata_pkg::REG_SENSOR_PRESENT) begin
			sensor_on = value[0];
		end
	endfunction

	function logic [31:0] sensor_reg();
		return {31'b0, sensor_on};
	endfunction

	// atan(2^-i) in degrees * 65536, nearest
	function longint atan_step_q16(int i);
		case (i)
			0: return 2949120;
			1: return 1740967;
			2: return 919879;
			3: return 466945;
			4: return 234379;
			5: return 117304;
			6: return 58666;
			7: return 29335;
			8: return 14668;
			9: return 7334;
			10: return 3667;
			11: return 1833;
			12: return 917;
			13: return 458;
			14: return 229;
			15: return 115;
			16: return 57;
			17: return 29;
			18: return 14;
			19: return 7;
			20: return 4;
			21: return 2;
			22: return 1;
			default: return 0;
		endcase
	endfunction

	function logic signed [ata_pkg::ANG_W-1:0] cordic_atan2(longint num, longint den);
		longint vx;
		longint vy;
		longint acc;
		longint xs;
		longint ys;
		longint res;
		if (num == 0) begin
			return (den < 0) ? ata_pkg::ANG_W'(ANGLE_LIMIT) : '0;
		end
		acc = 0;
		vx = den * 256;
		vy = num * 256;
		// left half plane: fold over and start from plus or minus half a turn
		if (den < 0) begin
			acc = (num > 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
			vx = -vx;
			vy = -vy;
		end
		for (int i = 0; i < cordic_steps && i < ATAN_ENTRIES; i++) begin
			xs = vx >>> i;
			ys = vy >>> i;
			if (vy >= 0) begin
				vx = vx + ys;
				vy = vy - xs;
				acc = acc + atan_step_q16(i);
			end else begin
				vx = vx - ys;
				vy = vy + xs;
				acc = acc - atan_step_q16(i);
			end
		end
		res = (acc + 128) >>> 8;
		if (res > ANGLE_LIMIT) res = ANGLE_LIMIT;
		if (res < -ANGLE_LIMIT) res = -ANGLE_LIMIT;
		return ata_pkg::ANG_W'(res);
	endfunction

	function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az);
		tilt_result_t r;
		if (!sensor_on) begin
			r.roll = '0;
			r.pitch = '0;
			r.status = STATUS_NO_SENSOR;
		end else begin
			r.roll = cordic_atan2(ax, az);
			r.pitch = cordic_atan2(ay, az);
			r.status = STATUS_OK;
		end
		pending_angles.push_back(r);
		samples++;
	endfunction

	function void check_angles(logic signed [ata_pkg::ANG_W-1:0] roll,
			logic signed [ata_pkg::ANG_W-1:0] pitch, logic status);
		tilt_result_t want;
		if (pending_angles.size() == 0) begin
			$error("result with no sample pending: roll %0d pitch %0d status %0b",
				roll, pitch, status);
			errors++;
			return;
		end
		want = pending_angles.pop_front();
		checked++;
		if (roll !== want.roll) begin
			$error("roll_angle: expected %0d, got %0d", want.roll, roll);
			errors++;
		end
		if (pitch !== want.pitch) begin
			$error("pitch_angle: expected %0d, got %0d", want.pitch, pitch);
			errors++;
		end
		if (status !== want.status) begin
			$error("status: expected %0b, got %0b", want.status, status);
			errors++;
		end
	endfunction

	function int outstanding();
		return pending_angles.size();
	endfunction
endclass

module accel_tilt_angles_test;
	localparam int   CORDIC_STEPS   = 16;
	localparam int   WATCHDOG_LIMIT = 3000;
	localparam int   BURST_PRESENT  = 240;
	localparam int   BURST_ABSENT   = 40;
	localparam logic [ata_pkg::ADDR_W-1:0] ADDR_SENSOR = {ata_pkg::REG_SENSOR_PRESENT, 2'b00};
	localparam logic [ata_pkg::ADDR_W-1:0] ADDR_SPARE  = 3'd4;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic signed [ata_pkg::AXIS_W-1:0] accel_x = '0;
	logic signed [ata_pkg::AXIS_W-1:0] accel_y = '0;
	logic signed [ata_pkg::AXIS_W-1:0] accel_z = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic signed [ata_pkg::ANG_W-1:0]  roll_angle;
	logic signed [ata_pkg::ANG_W-1:0]  pitch_angle;
	logic                              status;
	logic                              psel = 1'b0;
	logic                              penable = 1'b0;
	logic                              pwrite = 1'b0;
	logic [ata_pkg::ADDR_W-1:0]        paddr = '0;
	logic [ata_pkg::DATA_W-1:0]        pwdata = '0;
	logic [ata_pkg::DATA_W-1:0]        prdata;
	logic                              pready;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	angle_scoreboard board = new(CORDIC_STEPS);

	accel_tilt_angles #(.CORDIC_ITERATIONS(CORDIC_STEPS)) dut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// result checking and the watchdog on handshake progress
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				board.check_angles(roll_angle, pitch_angle, status);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: %0d results still pending", board.outstanding());
				$display("accel_tilt_angles verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_sample(input logic signed [15:0] sx, input logic signed [15:0] sy,
			input logic signed [15:0] sz);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		accel_x <= sx;
		accel_y <= sy;
		accel_z <= sz;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_sample(sx, sy, sz);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		// let the pipeline run empty so a stray result would still show up
		repeat (CORDIC_STEPS + 2) @(posedge clk);
	endtask

	task automatic reg_write(input logic [ata_pkg::ADDR_W-1:0] addr,
			input logic [ata_pkg::DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		board.write_reg(addr[2], data);
		@(posedge clk);
	endtask

	task automatic sensor_readback();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_SENSOR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== board.sensor_reg()) begin
			$error("sensor_present: expected %0h, got %0h", board.sensor_reg(), prdata);
			board.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_sensor(input logic on);
		reg_write(ADDR_SENSOR, {$urandom} & 32'hffff_fffe | {31'b0, on});
		sensor_readback();
	endtask

	function automatic logic signed [15:0] pick_axis();
		int kind;
		kind = $urandom_range(9);
		if (kind <= 3) return 16'($urandom);
		if (kind <= 5) return 16'($urandom_range(8)) - 16'sd4;
		if (kind <= 7) begin
			case ($urandom_range(5))
				0: return 16'sh8000;
				1: return 16'sh8001;
				2: return -16'sd1;
				3: return 16'sd0;
				4: return 16'sd1;
				default: return 16'sh7fff;
			endcase
		end
		return 16'($urandom_range(4000)) - 16'sd2000;
	endfunction

	task automatic random_burst(input int count);
		repeat (count) send_sample(pick_axis(), pick_axis(), pick_axis());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sensor absent out of reset
		send_sample(16'sh7fff, 16'sh8000, -16'sd1);
		send_sample(16'sd0, 16'sd0, 16'sd0);
		send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
		drain();
		// the spare index must not reach the sensor flag
		reg_write(ADDR_SPARE, 32'hffff_ffff);
		sensor_readback();
		send_sample(16'sd100, 16'sd100, 16'sd100);
		drain();

		set_sensor(1'b1);
		send_sample(16'sd0, 16'sd0, 16'sd0);
		send_sample(16'sd0, 16'sd0, -16'sd5);
		send_sample(16'sd0, 16'sd0, 16'sd5);
		send_sample(16'sd1, -16'sd1, 16'sd0);
		send_sample(16'sd0, 16'sd7, -16'sd3);
		send_sample(16'sd100, -16'sd100, -16'sd1);
		send_sample(16'sh7fff, 16'sh8000, 16'sh8000);
		send_sample(16'sh8000, 16'sh7fff, 16'sh7fff);
		send_sample(16'sh8000, 16'sh8000, 16'sh8000);
		send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_sample(16'sd1, 16'sd1, 16'sh8000);
		send_sample(-16'sd1, -16'sd1, 16'sh7fff);
		send_sample(16'sh7fff, 16'sh8000, 16'sd1);
		send_sample(16'sh8000, 16'sh7fff, -16'sd1);
		send_sample(16'sd16384, -16'sd16384, 16'sd16384);
		send_sample(16'sh7fff, 16'sh8000, 16'sd0);
		drain();
		reg_write(ADDR_SPARE, 32'h0000_0000);
		sensor_readback();

		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 87; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 87; end
				default: begin send_idle_pct = 31; stall_pct = 31; end
			endcase
			set_sensor(1'b1);
			random_burst(BURST_PRESENT);
			drain();
			set_sensor(1'b0);
			reg_write(ADDR_SPARE, $urandom | 32'h1);
			sensor_readback();
			random_burst(BURST_ABSENT);
			drain();
		end

		$display("%0d samples sent and %0d results checked, sensor present and absent,",
			board.samples, board.checked);
		$display("under free flow, sender gaps, output stalls and both mixed");
		if (board.errors == 0 && board.outstanding() == 0) begin
			$display("accel_tilt_angles verification clean");
		end else begin
			$display("accel_tilt_angles verification failed");
		end
		$finish;
	end
endmodule
